// ----- hdl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Types and constants shared by the sensor line parser modules.
// ----------------------------------------------------------------------------
package csp_pkg;

  // input word: a received byte or a millisecond tick
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  // result word, one per input word
  typedef struct packed {
    logic signed [8:0]  error_x;
    logic [13:0]        distance;
    logic signed [15:0] object_type;
    logic               online;
    logic               frame_valid;
  } out_word_t;

  // line parser to link tracker: a completed, range-checked line
  typedef struct packed {
    logic               accept;
    logic signed [8:0]  error_x;
    logic [13:0]        distance;
    logic signed [15:0] object_type;
  } frame_t;

  // field scan phase
  typedef enum logic [2:0] {
    PH_BLANKS = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic signed [15:0] ERR_MIN  = -16'sd160;
  localparam logic signed [15:0] ERR_MAX  = 16'sd160;
  localparam logic signed [15:0] DIST_MIN = 16'sd0;
  localparam logic signed [15:0] DIST_MAX = 16'sd10000;
  localparam logic signed [20:0] ACC_MAX  = 21'sd32767;
  localparam logic signed [20:0] ACC_MIN  = -21'sd32768;

  localparam logic [1:0]  LAST_FIELD      = 2'd2;
  localparam logic [15:0] TIMEOUT_DEFAULT = 16'd500;
  localparam logic [15:0] TICKS_MAX       = 16'hFFFF;

endpackage

// ----- hdl/csp_line_parser.sv -----
// ----------------------------------------------------------------------------
// csp_line_parser
// Byte-level CSV line state: capacity count, field scan and accumulators.
// ----------------------------------------------------------------------------
module csp_line_parser #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  csp_pkg::in_word_t word,
  output csp_pkg::frame_t frame
);
  import csp_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         idx_r, idx_nxt;
  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic               term_r, term_nxt;
  logic signed [15:0] acc_r [3];
  logic signed [15:0] acc_nxt [3];

  logic [1:0]         f;
  logic signed [15:0] acc_sel;
  logic signed [20:0] acc_ext, prod, sum, sat;
  logic signed [20:0] digit;
  logic               is_digit, is_blank, is_sign, range_ok;
  logic [7:0]         c;

  assign c        = word.rx_byte;
  assign f        = (idx_r == 2'd3) ? LAST_FIELD : idx_r;
  assign acc_sel  = acc_r[f];
  assign acc_ext  = {{5{acc_sel[15]}}, acc_sel};
  assign prod     = (acc_ext <<< 3) + (acc_ext <<< 1);
  assign digit    = {17'd0, c[3:0]};
  assign sum      = neg_r ? prod - digit : prod + digit;
  assign sat      = (sum > ACC_MAX) ? ACC_MAX : ((sum < ACC_MIN) ? ACC_MIN : sum);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
  assign range_ok = (acc_r[0] >= ERR_MIN) && (acc_r[0] <= ERR_MAX) &&
                    (acc_r[1] >= DIST_MIN) && (acc_r[1] <= DIST_MAX);

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    term_nxt  = term_r;
    for (int i = 0; i < 3; i++) acc_nxt[i] = acc_r[i];

    frame.accept      = 1'b0;
    frame.error_x     = acc_r[0][8:0];
    frame.distance    = acc_r[1][13:0];
    frame.object_type = acc_r[2];

    if (step_en && word.cmd == CMD_BYTE && c != CH_CR) begin
      if (c == CH_LF || count_r >= CNT_LAST) begin
        frame.accept = (c == CH_LF) && (idx_r == LAST_FIELD) && range_ok;
        count_nxt = '0;
        idx_nxt   = '0;
        phase_nxt = PH_BLANKS;
        neg_nxt   = 1'b0;
        term_nxt  = 1'b0;
        for (int i = 0; i < 3; i++) acc_nxt[i] = '0;
      end else begin
        count_nxt = count_r + 1'b1;
        if (!term_r) begin
          // atoi-style scan of the current field
          if (c == CH_NUL) begin
            term_nxt = 1'b1;
          end else if (c == CH_COMMA && idx_r < LAST_FIELD) begin
            idx_nxt   = idx_r + 1'b1;
            phase_nxt = PH_BLANKS;
            neg_nxt   = 1'b0;
          end else if (phase_r != PH_DONE) begin
            if (is_digit) begin
              acc_nxt[f] = sat[15:0];
              phase_nxt  = PH_DIGITS;
            end else if (phase_r == PH_BLANKS && is_blank) begin
              phase_nxt = PH_BLANKS;
            end else if (phase_r == PH_BLANKS && is_sign) begin
              neg_nxt   = (c == CH_MINUS);
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      phase_r <= PH_BLANKS;
      neg_r   <= 1'b0;
      term_r  <= 1'b0;
      for (int i = 0; i < 3; i++) acc_r[i] <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      term_r  <= term_nxt;
      for (int i = 0; i < 3; i++) acc_r[i] <= acc_nxt[i];
    end
  end

endmodule

// ----- hdl/csp_link_tracker.sv -----
// ----------------------------------------------------------------------------
// csp_link_tracker
// Held frame values, tick counter and online/timeout status.
// ----------------------------------------------------------------------------
module csp_link_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              cmd,
  input  logic [15:0]       timeout_ms,
  input  csp_pkg::frame_t   frame,
  output csp_pkg::out_word_t result
);
  import csp_pkg::*;

  logic signed [8:0]  err_r, err_nxt;
  logic [13:0]        dist_r, dist_nxt;
  logic signed [15:0] obj_r, obj_nxt;
  logic               online_r, online_nxt;
  logic [15:0]        ticks_r, ticks_nxt;

  always_comb begin
    err_nxt    = err_r;
    dist_nxt   = dist_r;
    obj_nxt    = obj_r;
    online_nxt = online_r;
    ticks_nxt  = ticks_r;
    if (step_en) begin
      if (cmd == CMD_TICK) begin
        if (ticks_r != TICKS_MAX) ticks_nxt = ticks_r + 1'b1;
        if (ticks_nxt > timeout_ms) begin
          online_nxt = 1'b0;
          obj_nxt    = '0;
        end
      end else if (frame.accept) begin
        err_nxt    = frame.error_x;
        dist_nxt   = frame.distance;
        obj_nxt    = frame.object_type;
        online_nxt = 1'b1;
        ticks_nxt  = '0;
      end
    end
    result.error_x     = err_nxt;
    result.distance    = dist_nxt;
    result.object_type = obj_nxt;
    result.online      = online_nxt;
    result.frame_valid = step_en && (cmd == CMD_BYTE) && frame.accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r    <= '0;
      dist_r   <= '0;
      obj_r    <= '0;
      online_r <= 1'b0;
      ticks_r  <= '0;
    end else begin
      err_r    <= err_nxt;
      dist_r   <= dist_nxt;
      obj_r    <= obj_nxt;
      online_r <= online_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

endmodule

// ----- hdl/csv_sensor_line_parser.sv -----
// ----------------------------------------------------------------------------
// csv_sensor_line_parser
// Streaming parser for "error,distance,object" report lines with link timeout.
//
//   channel  direction  handshake              word
//   in_      input      in_valid / in_ready    byte or millisecond tick
//   out_     output     out_valid / out_ready  held values, online, frame_valid
//   cfg_     input      cfg_we                 timeout_ms
//
// One word per cycle while the output is not stalled: an input register feeds
// the parse/update logic, whose result is loaded into the output register in
// the same cycle it is applied; out_valid is set by that output register load.
// Reset (rst_n low, synchronous) clears both registers, the line state and
// the link state; timeout_ms returns to 500. A stalled output holds the input
// register, and in_ready drops only while both stages are full.
// ----------------------------------------------------------------------------
module csv_sensor_line_parser #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  csp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output csp_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);
  import csp_pkg::*;

  logic       in_valid_r;
  in_word_t   in_word_r;
  logic       out_valid_r;
  out_word_t  out_word_r;
  logic [15:0] timeout_r;
  logic       step_en;
  frame_t     frame;
  out_word_t  result;

  // a word is applied when the output register is free or being emptied
  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  csp_line_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .word   (in_word_r),
    .frame  (frame)
  );

  csp_link_tracker u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .cmd       (in_word_r.cmd),
    .timeout_ms(timeout_r),
    .frame     (frame),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_DEFAULT;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_word_r <= in_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) out_word_r <= result;
  end

endmodule
